/* design/grmn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package grmn_pkg;

  localparam int unsigned MAX_DIM_DEF   = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ELEM_W        = 18;
  localparam int unsigned SUM_W         = 22;
  localparam int unsigned DIM_REG_W     = 5;
  // widest column index over the whole parameter range (64 columns)
  localparam int unsigned IDX_MAX_W     = 6;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // configuration register indexes (bit 2 of the byte address)
  localparam logic REG_IN_DIM  = 1'b0;
  localparam logic REG_OUT_DIM = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_READ,
    OP_PROPOSE,
    OP_ACCEPT
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_NOCAND
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_SUM,
    S_RD_WAIT,
    S_WALK,
    S_SCAN,
    S_ACC_COPY,
    S_DONE
  } state_e;

  // column step handed to the rotator
  typedef struct packed {
    logic                 valid;
    logic                 rotate;
    logic                 counted;
    logic [IDX_MAX_W-1:0] col;
  } rot_ctl_t;

  // rotated column pair coming back from the rotator
  typedef struct packed {
    logic                     valid;
    logic                     counted;
    logic [IDX_MAX_W-1:0]     col;
    logic signed [ELEM_W-1:0] r1;
    logic signed [ELEM_W-1:0] r2;
  } rot_res_t;

  // add an absolute value to a row sum, saturating
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic signed [ELEM_W-1:0] v);
    logic signed [ELEM_W:0] ext;
    logic [ELEM_W:0]        mag;
    logic [SUM_W:0]         t;
    ext = (ELEM_W+1)'(v);
    mag = ext[ELEM_W] ? (ELEM_W+1)'(-ext) : (ELEM_W+1)'(ext);
    t   = (SUM_W+1)'(s) + (SUM_W+1)'(mag);
    return (t > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : t[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* design/grmn_mat_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module grmn_mat_ram
  import grmn_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [2*$clog2(MAX_DIM)-1:0] waddr_i,
  input  wire logic signed [ELEM_W-1:0] wdata_i,
  input  wire logic [2*$clog2(MAX_DIM)-1:0] raddr_a_i,
  input  wire logic [2*$clog2(MAX_DIM)-1:0] raddr_b_i,
  output logic signed [ELEM_W-1:0]      rdata_a_o,
  output logic signed [ELEM_W-1:0]      rdata_b_o
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

  logic signed [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

/* design/grmn_cand_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module grmn_cand_ram
  import grmn_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [$clog2(MAX_DIM)-1:0]   waddr_i,
  input  wire logic [2*ELEM_W-1:0]          wdata_i,
  input  wire logic [$clog2(MAX_DIM)-1:0]   raddr_i,
  output logic [2*ELEM_W-1:0]               rdata_o
);

  // one entry per column: second row in the upper half
  logic [2*ELEM_W-1:0] mem [MAX_DIM];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* design/grmn_rotator.sv */
`timescale 1ns / 1ps
`default_nettype none
module grmn_rotator
  import grmn_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire rot_ctl_t                 ctl_i,
  input  wire logic signed [ELEM_W-1:0] m1_i,
  input  wire logic signed [ELEM_W-1:0] m2_i,
  input  wire logic signed [ELEM_W-1:0] cos_i,
  input  wire logic signed [ELEM_W-1:0] sin_i,
  output rot_res_t                      res_o,
  output logic                          busy_o
);

  localparam int unsigned P_W = 2 * ELEM_W;
  localparam int unsigned D_W = P_W + 2;
  localparam logic signed [D_W-1:0] RND  = D_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [D_W-1:0] EMAX = D_W'((2 ** (ELEM_W - 1)) - 1);
  localparam logic signed [D_W-1:0] EMIN = -EMAX - D_W'(1);

  rot_ctl_t                 ctl1_q, ctl2_q;
  logic signed [P_W-1:0]    cm1_q, sm2_q, sm1_q, cm2_q;
  logic signed [ELEM_W-1:0] m1_q, m2_q;
  logic signed [D_W-1:0]    v1, v2, q1, q2;
  logic signed [ELEM_W-1:0] r1, r2;

  // stage 1 lines up with the memory read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cm1_q <= P_W'(cos_i) * P_W'(m1_i);
    sm2_q <= P_W'(sin_i) * P_W'(m2_i);
    sm1_q <= P_W'(sin_i) * P_W'(m1_i);
    cm2_q <= P_W'(cos_i) * P_W'(m2_i);
    m1_q  <= m1_i;
    m2_q  <= m2_i;
  end

  // round half up, floor shift, saturate to the element range
  always_comb begin
    v1 = D_W'(cm1_q) - D_W'(sm2_q) + RND;
    v2 = D_W'(sm1_q) + D_W'(cm2_q) + RND;
    q1 = v1 >>> FRAC_BITS;
    q2 = v2 >>> FRAC_BITS;
    r1 = (q1 > EMAX) ? ELEM_W'(EMAX) : ((q1 < EMIN) ? ELEM_W'(EMIN) : ELEM_W'(q1));
    r2 = (q2 > EMAX) ? ELEM_W'(EMAX) : ((q2 < EMIN) ? ELEM_W'(EMIN) : ELEM_W'(q2));
  end

  assign res_o.valid   = ctl2_q.valid;
  assign res_o.counted = ctl2_q.counted;
  assign res_o.col     = ctl2_q.col;
  assign res_o.r1      = ctl2_q.rotate ? r1 : m1_q;
  assign res_o.r2      = ctl2_q.rotate ? r2 : m2_q;
  assign busy_o        = ctl1_q.valid | ctl2_q.valid;

endmodule
`default_nettype wire

/* design/givens_row_rotation_max_norm.sv */
`timescale 1ns / 1ps
`default_nettype none
// givens row rotation with row l1-norm maximum
// keeps a square matrix of Q2.16 elements and each row's absolute sum over
// the first n columns; in_dim and out_dim are set over the apb port
// (byte addresses 0 and 4); the user must set them only while the block
// is idle, and the block itself does not enforce this
// input transactions carry the opcode in tuser and the operands in tdata;
// each input transaction gives exactly one output transaction with max_sum
// and read_value in tdata and the status code in tuser
// one transaction is worked on at a time, in steps from accept to result:
//   load     element write, then a read-back sweep of the row over its n
//            counted columns, n the smaller of in_dim and the active size d
//   read     one matrix memory read
//   propose  column walk over all MAX_DIM columns through the matrix memory
//            read latency and the rotator pipeline, then a scan of the d row
//            sums, skipped at size one
//   accept   two element writes per column, paced by the single write port
//   any error status goes straight to the result stage
// a finished result sits in the output register while the next transaction
// is accepted; a stalled receiver holds the block in its result stage
// reset clears row sums, candidate and configuration (in_dim and out_dim 3);
// matrix and candidate memories are not cleared and hold garbage until written
module givens_row_rotation_max_norm
  import grmn_pkg::*;
#(
  parameter int unsigned MAX_DIM   = MAX_DIM_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: row[3:0] col[7:4] value[25:8] axis_first[29:26] axis_second[33:30]
  //        cos_value[51:34] sin_value[69:52], zero fill to 72
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [71:0] s_axis_tdata_i,
  // tuser: opcode[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: max_sum[21:0] read_value[39:22]
  output logic [39:0]      m_axis_tdata_o,
  // tuser: status[1:0]
  output logic [1:0]       m_axis_tuser_o,
  // apb configuration port
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);

  localparam int unsigned IDX_W = $clog2(MAX_DIM);
  localparam int unsigned AW    = 2 * IDX_W;
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned CNT_W = $clog2(2 * MAX_DIM + 1);
  localparam int unsigned EXT_W = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
  localparam logic [SUM_W-1:0] ONE_SUM =
    (FRAC_BITS >= SUM_W) ? SUM_MAX : (SUM_W'(1) << FRAC_BITS);

  // input fields
  op_e                      in_op;
  logic [3:0]               in_row, in_col, in_a1, in_a2;
  logic signed [ELEM_W-1:0] in_value, in_cos, in_sin;

  assign in_op    = op_e'(s_axis_tuser_i);
  assign in_row   = s_axis_tdata_i[3:0];
  assign in_col   = s_axis_tdata_i[7:4];
  assign in_value = s_axis_tdata_i[25:8];
  assign in_a1    = s_axis_tdata_i[29:26];
  assign in_a2    = s_axis_tdata_i[33:30];
  assign in_cos   = s_axis_tdata_i[51:34];
  assign in_sin   = s_axis_tdata_i[69:52];

  // configuration registers
  logic [DIM_REG_W-1:0] in_dim_q, out_dim_q;
  logic                 cfg_we;

  assign pready_o = 1'b1;
  assign cfg_we   = psel_i & penable_i & pwrite_i;
  assign prdata_o = (paddr_i[2] == REG_OUT_DIM) ? 32'(out_dim_q) : 32'(in_dim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_dim_q  <= DIM_REG_W'(3);
      out_dim_q <= DIM_REG_W'(3);
    end else if (cfg_we) begin
      if (paddr_i[2] == REG_OUT_DIM) begin
        out_dim_q <= pwdata_i[DIM_REG_W-1:0];
      end else begin
        in_dim_q <= pwdata_i[DIM_REG_W-1:0];
      end
    end
  end

  // active size d and counted columns n
  logic [EXT_W-1:0] od_ext, id_ext, d_ext, n_ext;
  logic [DIM_W-1:0] d, n;
  logic             single, ld_ok, ax_ok;

  always_comb begin
    od_ext = EXT_W'(out_dim_q);
    id_ext = EXT_W'(in_dim_q);
    if (od_ext == '0) begin
      d_ext = EXT_W'(1);
    end else if (od_ext > EXT_W'(MAX_DIM)) begin
      d_ext = EXT_W'(MAX_DIM);
    end else begin
      d_ext = od_ext;
    end
    n_ext  = (id_ext < d_ext) ? id_ext : d_ext;
    d      = DIM_W'(d_ext);
    n      = DIM_W'(n_ext);
    single = (d_ext == EXT_W'(1));
    ld_ok  = (EXT_W'(in_row) < d_ext) && (EXT_W'(in_col) < d_ext);
    ax_ok  = (EXT_W'(in_a1) < d_ext) && (EXT_W'(in_a2) < d_ext) && (in_a1 != in_a2);
  end

  // state
  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q;
  logic                     pend_q, pend_ph_q;
  logic [IDX_W-1:0]         pend_col_q;
  logic [IDX_W-1:0]         row_q, ax1_q, ax2_q;
  logic signed [ELEM_W-1:0] cos_q, sin_q;
  logic                     single_q;
  logic [SUM_W-1:0]         acc1_q, acc2_q, cs1_q, cs2_q, best_q;
  logic                     cand_valid_q;
  logic [SUM_W-1:0]         row_sums_q [MAX_DIM];
  logic [SUM_W-1:0]         res_max_q;
  logic signed [ELEM_W-1:0] res_rv_q;
  status_e                  res_st_q;
  logic                     out_valid_q;
  logic [SUM_W-1:0]         out_max_q;
  logic signed [ELEM_W-1:0] out_rv_q;
  status_e                  out_st_q;

  // memory and rotator hookup
  logic                     mat_we;
  logic [AW-1:0]            mat_waddr, mat_raddr_a, mat_raddr_b;
  logic signed [ELEM_W-1:0] mat_wdata, mat_rdata_a, mat_rdata_b;
  logic                     cand_we;
  logic [IDX_W-1:0]         cand_waddr, cand_raddr;
  logic [2*ELEM_W-1:0]      cand_wdata, cand_rdata;
  rot_ctl_t                 rot_ctl;
  rot_res_t                 rot_res;
  logic                     rot_busy;

  logic             in_acc, issue, finish, out_load;
  logic [SUM_W-1:0] scan_val;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_load        = (state_q == S_DONE) & (~out_valid_q | m_axis_tready_i);

  // sequencing conditions of the sweeping states
  always_comb begin
    issue  = 1'b0;
    finish = 1'b0;
    case (state_q)
      S_LD_SUM: begin
        issue  = cnt_q < CNT_W'(n);
        finish = ~issue & ~pend_q;
      end
      S_WALK: begin
        issue  = cnt_q < CNT_W'(MAX_DIM);
        finish = ~issue & ~rot_busy;
      end
      S_SCAN: begin
        issue  = cnt_q < CNT_W'(d);
        finish = ~issue;
      end
      S_ACC_COPY: begin
        issue  = cnt_q < CNT_W'(2 * MAX_DIM);
        finish = ~issue & ~pend_q;
      end
      default: begin
        issue  = 1'b0;
        finish = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_LOAD:    state_d = ld_ok ? S_LD_SUM : S_DONE;
            OP_READ:    state_d = ld_ok ? S_RD_WAIT : S_DONE;
            OP_PROPOSE: state_d = (single | ax_ok) ? S_WALK : S_DONE;
            OP_ACCEPT:  state_d = cand_valid_q ? S_ACC_COPY : S_DONE;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_LD_SUM:   state_d = finish ? S_DONE : S_LD_SUM;
      S_RD_WAIT:  state_d = S_DONE;
      S_WALK:     state_d = finish ? (single_q ? S_DONE : S_SCAN) : S_WALK;
      S_SCAN:     state_d = finish ? S_DONE : S_SCAN;
      S_ACC_COPY: state_d = finish ? S_DONE : S_ACC_COPY;
      S_DONE:     state_d = out_load ? S_IDLE : S_DONE;
      default:    state_d = S_IDLE;
    endcase
  end

  // memory ports and rotator control
  always_comb begin
    mat_we      = 1'b0;
    mat_waddr   = {ax1_q, pend_col_q};
    mat_wdata   = cand_rdata[ELEM_W-1:0];
    mat_raddr_a = {row_q, cnt_q[IDX_W-1:0]};
    mat_raddr_b = {ax2_q, cnt_q[IDX_W-1:0]};
    cand_raddr  = cnt_q[IDX_W:1];
    rot_ctl     = '0;
    case (state_q)
      S_IDLE: begin
        // element write and read address come straight from the input
        mat_we      = in_acc & (in_op == OP_LOAD) & ld_ok;
        mat_waddr   = {IDX_W'(in_row), IDX_W'(in_col)};
        mat_wdata   = in_value;
        mat_raddr_a = {IDX_W'(in_row), IDX_W'(in_col)};
      end
      S_WALK: begin
        mat_raddr_a     = {ax1_q, cnt_q[IDX_W-1:0]};
        rot_ctl.valid   = issue;
        rot_ctl.rotate  = ~single_q & (cnt_q < CNT_W'(d));
        rot_ctl.counted = cnt_q < CNT_W'(n);
        rot_ctl.col     = IDX_MAX_W'(cnt_q[IDX_W-1:0]);
      end
      S_ACC_COPY: begin
        mat_we    = pend_q;
        mat_waddr = {pend_ph_q ? ax2_q : ax1_q, pend_col_q};
        mat_wdata = pend_ph_q ? cand_rdata[2*ELEM_W-1:ELEM_W] : cand_rdata[ELEM_W-1:0];
      end
      default: begin
        mat_we = 1'b0;
      end
    endcase
    cand_we    = rot_res.valid;
    cand_waddr = rot_res.col[IDX_W-1:0];
    cand_wdata = {rot_res.r2, rot_res.r1};
  end

  // row sum with the candidate sums standing in for the rotated rows
  always_comb begin
    if (cnt_q[IDX_W-1:0] == ax1_q) begin
      scan_val = cs1_q;
    end else if (cnt_q[IDX_W-1:0] == ax2_q) begin
      scan_val = cs2_q;
    end else begin
      scan_val = row_sums_q[cnt_q[IDX_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      cand_valid_q <= 1'b0;
      cs1_q        <= '0;
      cs2_q        <= '0;
      ax1_q        <= '0;
      ax2_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < MAX_DIM; i++) begin
        row_sums_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      pend_q  <= 1'b0;
      if (issue) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      case (state_q)
        S_IDLE: begin
          cnt_q <= '0;
          if (in_acc && in_op == OP_LOAD && ld_ok) begin
            cand_valid_q <= 1'b0;
          end
          if (in_acc && in_op == OP_PROPOSE) begin
            if (single) begin
              ax1_q <= '0;
              ax2_q <= '0;
            end else if (ax_ok) begin
              ax1_q <= IDX_W'(in_a1);
              ax2_q <= IDX_W'(in_a2);
            end
          end
        end
        S_LD_SUM: begin
          pend_q <= issue;
          if (finish) begin
            row_sums_q[row_q] <= acc1_q;
          end
        end
        S_WALK: begin
          if (finish) begin
            cs1_q        <= single_q ? row_sums_q[0] : acc1_q;
            cs2_q        <= single_q ? row_sums_q[0] : acc2_q;
            cand_valid_q <= 1'b1;
            cnt_q        <= '0;
          end
        end
        S_ACC_COPY: begin
          pend_q <= issue;
          if (finish) begin
            row_sums_q[ax1_q] <= cs1_q;
            row_sums_q[ax2_q] <= cs2_q;
            cand_valid_q      <= 1'b0;
          end
        end
        default: begin
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        acc1_q    <= '0;
        acc2_q    <= '0;
        best_q    <= '0;
        row_q     <= IDX_W'(in_row);
        cos_q     <= in_cos;
        sin_q     <= in_sin;
        single_q  <= single;
        res_max_q <= '0;
        res_rv_q  <= '0;
        res_st_q  <= ST_OK;
        if (in_acc) begin
          case (in_op)
            OP_LOAD, OP_READ: begin
              if (!ld_ok) res_st_q <= ST_RANGE;
            end
            OP_PROPOSE: begin
              if (!single && !ax_ok) res_st_q <= ST_RANGE;
            end
            OP_ACCEPT: begin
              if (!cand_valid_q) res_st_q <= ST_NOCAND;
            end
            default: begin
              res_st_q <= ST_OK;
            end
          endcase
        end
      end
      S_LD_SUM: begin
        if (pend_q) begin
          acc1_q <= sat_add(acc1_q, mat_rdata_a);
        end
      end
      S_RD_WAIT: begin
        res_rv_q <= mat_rdata_a;
      end
      S_WALK: begin
        if (rot_res.valid && rot_res.counted) begin
          acc1_q <= sat_add(acc1_q, rot_res.r1);
          acc2_q <= sat_add(acc2_q, rot_res.r2);
        end
        if (finish && single_q) begin
          res_max_q <= ONE_SUM;
        end
      end
      S_SCAN: begin
        if (issue && scan_val > best_q) begin
          best_q <= scan_val;
        end
        if (finish) begin
          res_max_q <= best_q;
        end
      end
      S_ACC_COPY: begin
        pend_col_q <= cnt_q[IDX_W:1];
        pend_ph_q  <= cnt_q[0];
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_max_q <= res_max_q;
      out_rv_q  <= res_rv_q;
      out_st_q  <= res_st_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_rv_q, out_max_q};
  assign m_axis_tuser_o  = out_st_q;

  grmn_mat_ram #(
    .MAX_DIM (MAX_DIM)
  ) u_mat_ram (
    .clk_i     (clk_i),
    .we_i      (mat_we),
    .waddr_i   (mat_waddr),
    .wdata_i   (mat_wdata),
    .raddr_a_i (mat_raddr_a),
    .raddr_b_i (mat_raddr_b),
    .rdata_a_o (mat_rdata_a),
    .rdata_b_o (mat_rdata_b)
  );

  grmn_cand_ram #(
    .MAX_DIM (MAX_DIM)
  ) u_cand_ram (
    .clk_i   (clk_i),
    .we_i    (cand_we),
    .waddr_i (cand_waddr),
    .wdata_i (cand_wdata),
    .raddr_i (cand_raddr),
    .rdata_o (cand_rdata)
  );

  grmn_rotator #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotator (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rot_ctl),
    .m1_i   (mat_rdata_a),
    .m2_i   (mat_rdata_b),
    .cos_i  (cos_q),
    .sin_i  (sin_q),
    .res_o  (rot_res),
    .busy_o (rot_busy)
  );

endmodule
`default_nettype wire
